@@ hw/rtl/srat_pkg.sv @@
package srat_pkg;

  localparam int unsigned KEY_W    = 48;
  localparam int unsigned DST_W    = 48;
  localparam int unsigned FMT_W    = 31;
  localparam int unsigned TIME_W   = 40;
  localparam int unsigned TMO_W    = 32;
  localparam logic [TMO_W-1:0] TIMEOUT_RESET_MS = TMO_W'(3 * 30 * 1000);

  typedef enum logic [1:0] {
    OP_REPORT   = 2'd0,
    OP_WITHDRAW = 2'd1,
    OP_TOUCH    = 2'd2,
    OP_SWEEP    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_UPDATED   = 3'd0,
    ST_INSERTED  = 3'd1,
    ST_FULL      = 3'd2,
    ST_WITHDRAWN = 3'd3,
    ST_TOUCHED   = 3'd4,
    ST_SWEPT     = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WRITE,
    S_FINISH
  } state_t;

  typedef struct packed {
    op_t               op;
    logic [15:0]       id_hash;
    logic [31:0]       src_ip;
    logic [31:0]       group_ip;
    logic [15:0]       udp_port;
    logic [6:0]        channels;
    logic [5:0]        sample_bits;
    logic [17:0]       rate_hz;
    logic [TIME_W-1:0] now_ms;
  } req_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [DST_W-1:0]  dst;
    logic [FMT_W-1:0]  fmt;
    logic [TIME_W-1:0] seen;
  } entry_t;

  typedef struct packed {
    logic rd_en;
    logic we_all;
    logic we_seen;
  } mem_ctl_t;

  typedef struct packed {
    logic key_eq;
    logic hash_eq;
    logic expired;
  } match_t;

endpackage

@@ hw/rtl/srat_store.sv @@
module srat_store #(
  parameter int unsigned ENTRIES = 16,
  parameter int unsigned IW      = 4
) (
  input  logic               clk,
  input  srat_pkg::mem_ctl_t ctl,
  input  logic [IW-1:0]      rd_addr,
  input  logic [IW-1:0]      wr_addr,
  input  srat_pkg::entry_t   wr_data,
  output srat_pkg::entry_t   rd_data
);
  import srat_pkg::*;

  logic [KEY_W-1:0]  key_mem  [ENTRIES];
  logic [DST_W-1:0]  dst_mem  [ENTRIES];
  logic [FMT_W-1:0]  fmt_mem  [ENTRIES];
  logic [TIME_W-1:0] seen_mem [ENTRIES];
  entry_t            rd_data_r;

  always_ff @(posedge clk) begin
    if (ctl.we_all) begin
      key_mem[wr_addr] <= wr_data.key;
      dst_mem[wr_addr] <= wr_data.dst;
      fmt_mem[wr_addr] <= wr_data.fmt;
    end
    if (ctl.we_all || ctl.we_seen) begin
      seen_mem[wr_addr] <= wr_data.seen;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data_r.key  <= key_mem[rd_addr];
      rd_data_r.dst  <= dst_mem[rd_addr];
      rd_data_r.fmt  <= fmt_mem[rd_addr];
      rd_data_r.seen <= seen_mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ hw/rtl/srat_match.sv @@
module srat_match (
  input  srat_pkg::entry_t           ent,
  input  logic [15:0]                id_hash,
  input  logic [31:0]                src_ip,
  input  logic [srat_pkg::TIME_W-1:0] now_ms,
  input  logic [srat_pkg::TMO_W-1:0]  timeout_ms,
  output srat_pkg::match_t           res
);
  import srat_pkg::*;

  logic [TIME_W-1:0] age;

  // age wraps with the time base
  assign age         = now_ms - ent.seen;
  assign res.key_eq  = (ent.key == {id_hash, src_ip});
  assign res.hash_eq = (ent.key[KEY_W-1:32] == id_hash);
  assign res.expired = (age > {{(TIME_W-TMO_W){1'b0}}, timeout_ms});

endmodule

@@ hw/rtl/srat_seq.sv @@
module srat_seq #(
  parameter int unsigned ENTRIES = 16,
  parameter int unsigned IW      = 4,
  parameter int unsigned CW      = 5
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  srat_pkg::req_t             req,
  input  logic [srat_pkg::TMO_W-1:0] timeout_ms,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [2:0]                 out_status,
  output logic [3:0]                 out_slot,
  output logic [4:0]                 out_affected_count,
  output logic [4:0]                 out_valid_count,
  output srat_pkg::mem_ctl_t         mem_ctl,
  output logic [IW-1:0]              rd_addr,
  output logic [IW-1:0]              wr_addr,
  output srat_pkg::entry_t           wr_data,
  input  srat_pkg::entry_t           rd_data
);
  import srat_pkg::*;

  state_t        state_r, state_nxt;
  req_t          req_r, req_nxt;
  logic          valid_r [ENTRIES];
  logic          valid_nxt [ENTRIES];
  logic [CW-1:0] vcnt_r, vcnt_nxt;
  logic [CW-1:0] rd_cnt_r, rd_cnt_nxt;
  logic [CW-1:0] aff_r, aff_nxt;
  logic          ev_vld_r, ev_vld_nxt;
  logic [IW-1:0] ev_idx_r, ev_idx_nxt;
  logic          found_r, found_nxt;
  logic          free_r, free_nxt;
  logic [IW-1:0] tgt_r, tgt_nxt;
  logic [IW-1:0] free_idx_r, free_idx_nxt;
  logic          out_valid_r, out_valid_nxt;
  status_t       status_r, status_nxt;
  logic [3:0]    slot_r, slot_nxt;
  logic [4:0]    oaff_r, oaff_nxt;
  logic [4:0]    ovcnt_r, ovcnt_nxt;
  match_t        m;
  logic          cur_valid;

  srat_match u_match (
    .ent        (rd_data),
    .id_hash    (req_r.id_hash),
    .src_ip     (req_r.src_ip),
    .now_ms     (req_r.now_ms),
    .timeout_ms (timeout_ms),
    .res        (m)
  );

  assign cur_valid = valid_r[ev_idx_r];

  assign wr_data.key  = {req_r.id_hash, req_r.src_ip};
  assign wr_data.dst  = {req_r.group_ip, req_r.udp_port};
  assign wr_data.fmt  = {req_r.channels, req_r.sample_bits, req_r.rate_hz};
  assign wr_data.seen = req_r.now_ms;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      vcnt_r      <= '0;
      for (int i = 0; i < ENTRIES; i++) valid_r[i] <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      vcnt_r      <= vcnt_nxt;
      for (int i = 0; i < ENTRIES; i++) valid_r[i] <= valid_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    rd_cnt_r   <= rd_cnt_nxt;
    aff_r      <= aff_nxt;
    ev_vld_r   <= ev_vld_nxt;
    ev_idx_r   <= ev_idx_nxt;
    found_r    <= found_nxt;
    free_r     <= free_nxt;
    tgt_r      <= tgt_nxt;
    free_idx_r <= free_idx_nxt;
    status_r   <= status_nxt;
    slot_r     <= slot_nxt;
    oaff_r     <= oaff_nxt;
    ovcnt_r    <= ovcnt_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    valid_nxt     = valid_r;
    vcnt_nxt      = vcnt_r;
    rd_cnt_nxt    = rd_cnt_r;
    aff_nxt       = aff_r;
    ev_vld_nxt    = 1'b0;
    ev_idx_nxt    = ev_idx_r;
    found_nxt     = found_r;
    free_nxt      = free_r;
    tgt_nxt       = tgt_r;
    free_idx_nxt  = free_idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    status_nxt    = status_r;
    slot_nxt      = slot_r;
    oaff_nxt      = oaff_r;
    ovcnt_nxt     = ovcnt_r;
    in_ready      = 1'b0;
    mem_ctl       = '0;
    rd_addr       = rd_cnt_r[IW-1:0];
    wr_addr       = ev_idx_r;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          req_nxt    = req;
          rd_cnt_nxt = '0;
          aff_nxt    = '0;
          found_nxt  = 1'b0;
          free_nxt   = 1'b0;
          state_nxt  = S_SCAN;
        end
      end

      S_SCAN: begin
        // read issue runs one entry ahead of evaluation
        if (rd_cnt_r < CW'(ENTRIES)) begin
          mem_ctl.rd_en = 1'b1;
          ev_vld_nxt    = 1'b1;
          ev_idx_nxt    = rd_cnt_r[IW-1:0];
          rd_cnt_nxt    = rd_cnt_r + CW'(1);
        end else begin
          state_nxt = (req_r.op == OP_REPORT) ? S_WRITE : S_FINISH;
        end
        if (ev_vld_r) begin
          unique case (req_r.op)
            OP_REPORT: begin
              if (cur_valid && m.key_eq && !found_r) begin
                found_nxt = 1'b1;
                tgt_nxt   = ev_idx_r;
              end
              if (!cur_valid && !free_r) begin
                free_nxt     = 1'b1;
                free_idx_nxt = ev_idx_r;
              end
            end
            OP_WITHDRAW: begin
              if (cur_valid && m.hash_eq) begin
                valid_nxt[ev_idx_r] = 1'b0;
                aff_nxt             = aff_r + CW'(1);
              end
            end
            OP_TOUCH: begin
              if (cur_valid && m.hash_eq) begin
                mem_ctl.we_seen = 1'b1;
                aff_nxt         = aff_r + CW'(1);
              end
            end
            OP_SWEEP: begin
              if (cur_valid && m.expired) begin
                valid_nxt[ev_idx_r] = 1'b0;
                aff_nxt             = aff_r + CW'(1);
              end
            end
            default: ;
          endcase
        end
      end

      S_WRITE: begin
        wr_addr = found_r ? tgt_r : free_idx_r;
        if (found_r || free_r) begin
          mem_ctl.we_all     = 1'b1;
          valid_nxt[wr_addr] = 1'b1;
        end
        state_nxt = S_FINISH;
      end

      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          slot_nxt      = '0;
          oaff_nxt      = 5'(aff_r);
          unique case (req_r.op)
            OP_REPORT: begin
              if (found_r) begin
                status_nxt = ST_UPDATED;
                slot_nxt   = 4'(tgt_r);
                oaff_nxt   = 5'd1;
              end else if (free_r) begin
                status_nxt = ST_INSERTED;
                slot_nxt   = 4'(free_idx_r);
                oaff_nxt   = 5'd1;
                vcnt_nxt   = vcnt_r + CW'(1);
              end else begin
                status_nxt = ST_FULL;
                oaff_nxt   = 5'd0;
              end
            end
            OP_WITHDRAW: begin
              status_nxt = ST_WITHDRAWN;
              vcnt_nxt   = vcnt_r - aff_r;
            end
            OP_TOUCH: status_nxt = ST_TOUCHED;
            OP_SWEEP: begin
              status_nxt = ST_SWEPT;
              vcnt_nxt   = vcnt_r - aff_r;
            end
            default: ;
          endcase
          ovcnt_nxt = 5'(vcnt_nxt);
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_slot           = slot_r;
  assign out_affected_count = oaff_r;
  assign out_valid_count    = ovcnt_r;

endmodule

@@ hw/rtl/stream_registry_aging_table_unit.sv @@
// a transaction is accepted only in idle; it then scans every entry, a report adds a
// write step, and finish registers the result; in_ready stays low until finish ends,
// and a held result stalls finish, so one transaction is in flight at a time
// reset: synchronous active-low rst_n clears all valid marks, the valid count
// and the output; timeout returns to 90000 ms, entry data stays unwritten
module stream_registry_aging_table_unit #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [15:0] in_id_hash,
  input  logic [31:0] in_src_ip,
  input  logic [31:0] in_group_ip,
  input  logic [15:0] in_udp_port,
  input  logic [6:0]  in_channels,
  input  logic [5:0]  in_sample_bits,
  input  logic [17:0] in_rate_hz,
  input  logic [39:0] in_now_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [3:0]  out_slot,
  output logic [4:0]  out_affected_count,
  output logic [4:0]  out_valid_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);
  import srat_pkg::*;

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);

  logic [TMO_W-1:0] timeout_r;
  req_t             req;
  mem_ctl_t         mem_ctl;
  logic [IW-1:0]    rd_addr;
  logic [IW-1:0]    wr_addr;
  entry_t           wr_data;
  entry_t           rd_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET_MS;
    end else if (cfg_valid && cfg_ready) begin
      timeout_r <= cfg_data;
    end
  end

  assign req.op          = op_t'(in_op);
  assign req.id_hash     = in_id_hash;
  assign req.src_ip      = in_src_ip;
  assign req.group_ip    = in_group_ip;
  assign req.udp_port    = in_udp_port;
  assign req.channels    = in_channels;
  assign req.sample_bits = in_sample_bits;
  assign req.rate_hz     = in_rate_hz;
  assign req.now_ms      = in_now_ms;

  srat_store #(
    .ENTRIES(ENTRIES),
    .IW     (IW)
  ) u_store (
    .clk    (clk),
    .ctl    (mem_ctl),
    .rd_addr(rd_addr),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_data(rd_data)
  );

  srat_seq #(
    .ENTRIES(ENTRIES),
    .IW     (IW),
    .CW     (CW)
  ) u_seq (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .req               (req),
    .timeout_ms        (timeout_r),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_slot          (out_slot),
    .out_affected_count(out_affected_count),
    .out_valid_count   (out_valid_count),
    .mem_ctl           (mem_ctl),
    .rd_addr           (rd_addr),
    .wr_addr           (wr_addr),
    .wr_data           (wr_data),
    .rd_data           (rd_data)
  );

endmodule

@@ hw/rtl/srat_checker.sv @@
module srat_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_status,
  input logic [3:0]  out_slot,
  input logic [4:0]  out_affected_count,
  input logic [4:0]  out_valid_count
);
  import srat_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_slot)
      && $stable(out_affected_count) && $stable(out_valid_count))
    else $error("result changed while stalled");

  // one transaction in flight: the scan takes the cycle after acceptance
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted during scan");

  a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |-> out_slot == 4'd0 && out_affected_count == 5'd0)
    else $error("full table result carries slot or count");

  a_report_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_UPDATED || out_status == ST_INSERTED)
      |-> out_affected_count == 5'd1)
    else $error("report result without single affected entry");

  a_bulk_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_WITHDRAWN || out_status == ST_TOUCHED
      || out_status == ST_SWEPT) |-> out_slot == 4'd0)
    else $error("bulk operation reports a slot");

endmodule

bind stream_registry_aging_table_unit srat_checker u_srat_checker (.*);

@@ tb/tb_stream_registry_aging_table_unit.sv @@
`timescale 1ns / 1ps

module tb_stream_registry_aging_table_unit;
  import srat_pkg::*;

  localparam int ENTRIES        = 16;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASE_ITEMS    = 263;

  typedef struct {
    status_t     status;
    logic [3:0]  slot;
    logic [4:0]  affected;
    logic [4:0]  live_count;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_op = '0;
  logic [15:0] in_id_hash = '0;
  logic [31:0] in_src_ip = '0;
  logic [31:0] in_group_ip = '0;
  logic [15:0] in_udp_port = '0;
  logic [6:0]  in_channels = '0;
  logic [5:0]  in_sample_bits = '0;
  logic [17:0] in_rate_hz = '0;
  logic [39:0] in_now_ms = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_status;
  logic [3:0]  out_slot;
  logic [4:0]  out_affected_count;
  logic [4:0]  out_valid_count;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;

  // predictor copy of the table
  bit          tbl_live[ENTRIES];
  logic [47:0] tbl_key[ENTRIES];
  logic [39:0] tbl_seen[ENTRIES];
  logic [31:0] tbl_timeout = TIMEOUT_RESET_MS;

  req_t        request_q[$];
  reply_t      reply_q[$];
  req_t        held_req;
  int          mismatches = 0;
  int          quiet_cycles = 0;
  int          send_idle_pct = 22;
  int          recv_idle_pct = 50;

  // random stream state
  logic [15:0] hash_pool[6];
  logic [31:0] ip_pool[4];
  logic [39:0] now_cursor = '0;
  int unsigned step_span = 40000;

  stream_registry_aging_table_unit #(
    .ENTRIES(ENTRIES)
  ) i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_op             (in_op),
    .in_id_hash        (in_id_hash),
    .in_src_ip         (in_src_ip),
    .in_group_ip       (in_group_ip),
    .in_udp_port       (in_udp_port),
    .in_channels       (in_channels),
    .in_sample_bits    (in_sample_bits),
    .in_rate_hz        (in_rate_hz),
    .in_now_ms         (in_now_ms),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_slot          (out_slot),
    .out_affected_count(out_affected_count),
    .out_valid_count   (out_valid_count),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data)
  );

  always #5 clk = ~clk;

  task automatic flag_mismatch(string what, longint got, longint want);
    if (mismatches < 50)
      $display("%0t: %s mismatch, got %0d expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  function automatic reply_t registry_apply(req_t r);
    reply_t      rep;
    logic [47:0] key;
    logic [39:0] age;
    int          hit;
    int          free_slot;
    int          i;
    key = {r.id_hash, r.src_ip};
    rep.slot = '0;
    rep.affected = '0;
    rep.live_count = '0;
    hit = -1;
    free_slot = -1;
    case (r.op)
      OP_REPORT: begin
        // downward scan leaves the lowest match and the lowest free slot
        for (i = ENTRIES - 1; i >= 0; i--) begin
          if (tbl_live[i] && tbl_key[i] == key) hit = i;
          if (!tbl_live[i]) free_slot = i;
        end
        rep.status = ST_FULL;
        if (hit >= 0) begin
          rep.status = ST_UPDATED;
        end else if (free_slot >= 0) begin
          rep.status = ST_INSERTED;
          hit = free_slot;
        end
        if (hit >= 0) begin
          tbl_live[hit] = 1'b1;
          tbl_key[hit] = key;
          tbl_seen[hit] = r.now_ms;
          rep.slot = 4'(hit);
          rep.affected = 5'd1;
        end
      end
      OP_WITHDRAW, OP_TOUCH: begin
        rep.status = (r.op == OP_WITHDRAW) ? ST_WITHDRAWN : ST_TOUCHED;
        for (i = 0; i < ENTRIES; i++) begin
          if (tbl_live[i] && tbl_key[i][47:32] == r.id_hash) begin
            if (r.op == OP_WITHDRAW) tbl_live[i] = 1'b0;
            else tbl_seen[i] = r.now_ms;
            rep.affected++;
          end
        end
      end
      default: begin
        rep.status = ST_SWEPT;
        for (i = 0; i < ENTRIES; i++) begin
          if (tbl_live[i]) begin
            age = r.now_ms - tbl_seen[i];
            if (age > {8'h00, tbl_timeout}) begin
              tbl_live[i] = 1'b0;
              rep.affected++;
            end
          end
        end
      end
    endcase
    for (i = 0; i < ENTRIES; i++)
      if (tbl_live[i]) rep.live_count++;
    return rep;
  endfunction

  function automatic req_t build_req(op_t op, logic [15:0] hash, logic [31:0] src,
                                     logic [39:0] now);
    req_t r;
    r.op = op;
    r.id_hash = hash;
    r.src_ip = src;
    r.group_ip = $urandom;
    r.udp_port = 16'($urandom);
    r.channels = 7'($urandom_range(0, 64));
    r.sample_bits = 6'($urandom_range(0, 32));
    r.rate_hz = 18'($urandom_range(0, 192000));
    r.now_ms = now;
    return r;
  endfunction

  // mostly keys from a small pool so updates, shared hashes and a full table occur
  function automatic req_t roll_request();
    int          pick;
    op_t         op;
    logic [15:0] hash;
    logic [31:0] src;
    pick = $urandom_range(0, 99);
    if (pick < 45) op = OP_REPORT;
    else if (pick < 57) op = OP_WITHDRAW;
    else if (pick < 77) op = OP_TOUCH;
    else op = OP_SWEEP;
    hash = ($urandom_range(0, 9) == 0) ? 16'($urandom) : hash_pool[$urandom_range(0, 5)];
    src = ($urandom_range(0, 9) == 0) ? $urandom : ip_pool[$urandom_range(0, 3)];
    case ($urandom_range(0, 19))
      0, 1, 2, 3: ;
      4, 5, 6, 7, 8, 9, 10, 11, 12: now_cursor += $urandom_range(0, step_span);
      13, 14, 15, 16, 17: now_cursor += $urandom_range(0, step_span * 3);
      18: now_cursor -= $urandom_range(1, step_span);
      default: now_cursor = {8'($urandom), 32'($urandom)};
    endcase
    return build_req(op, hash, src, now_cursor);
  endfunction

  // driver
  always @(posedge clk) begin : drive_p
    logic next_valid;
    next_valid = in_valid;
    if (in_valid && in_ready) begin
      reply_q.push_back(registry_apply(held_req));
      next_valid = 1'b0;
    end
    if (!next_valid && rst_n && request_q.size() > 0 &&
        $urandom_range(0, 99) >= send_idle_pct) begin
      held_req = request_q.pop_front();
      in_op <= held_req.op;
      in_id_hash <= held_req.id_hash;
      in_src_ip <= held_req.src_ip;
      in_group_ip <= held_req.group_ip;
      in_udp_port <= held_req.udp_port;
      in_channels <= held_req.channels;
      in_sample_bits <= held_req.sample_bits;
      in_rate_hz <= held_req.rate_hz;
      in_now_ms <= held_req.now_ms;
      next_valid = 1'b1;
    end
    in_valid <= next_valid;
  end

  // monitor
  always @(posedge clk) begin : watch_p
    reply_t want;
    if (rst_n && out_valid && out_ready) begin
      if (reply_q.size() == 0) begin
        flag_mismatch("unexpected transaction, status", out_status, 0);
      end else begin
        want = reply_q.pop_front();
        if (out_status !== want.status)
          flag_mismatch("status", out_status, want.status);
        if (out_slot !== want.slot)
          flag_mismatch("slot", out_slot, want.slot);
        if (out_affected_count !== want.affected)
          flag_mismatch("affected_count", out_affected_count, want.affected);
        if (out_valid_count !== want.live_count)
          flag_mismatch("valid_count", out_valid_count, want.live_count);
      end
    end
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // checked away from the rising edge so a transaction just popped is seen as valid
  task automatic drain();
    while (request_q.size() != 0 || in_valid || reply_q.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_timeout(logic [31:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    tbl_timeout = value;
    cfg_valid <= 1'b0;
  endtask

  initial begin
    req_t        r;
    int          ph;
    int          k;
    logic [31:0] tmo;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // empty table, then extremes, update, shared hash, timeout boundary
    request_q.push_back(build_req(OP_SWEEP, 16'h0000, 32'h0, 40'd0));
    request_q.push_back(build_req(OP_WITHDRAW, 16'hFFFF, 32'h0, 40'd0));
    request_q.push_back(build_req(OP_TOUCH, 16'h0000, 32'h0, 40'd0));
    r = build_req(OP_REPORT, 16'h0000, 32'h0, 40'd0);
    r.group_ip = '0;
    r.udp_port = '0;
    r.channels = '0;
    r.sample_bits = '0;
    r.rate_hz = '0;
    request_q.push_back(r);
    r = build_req(OP_REPORT, 16'hFFFF, 32'hFFFF_FFFF, 40'hFF_FFFF_FFFF);
    r.group_ip = '1;
    r.udp_port = '1;
    r.channels = 7'd64;
    r.sample_bits = 6'd32;
    r.rate_hz = 18'd192000;
    request_q.push_back(r);
    request_q.push_back(build_req(OP_REPORT, 16'h0000, 32'h0, 40'd5));
    request_q.push_back(build_req(OP_REPORT, 16'hFFFF, 32'h1, 40'd10));
    request_q.push_back(build_req(OP_TOUCH, 16'hFFFF, 32'h0, 40'd20));
    // ages 90015 and 90000: only the first one goes
    request_q.push_back(build_req(OP_SWEEP, 16'h0000, 32'h0, 40'd90020));
    for (k = 1; k <= 14; k++)
      request_q.push_back(build_req(OP_REPORT, 16'(k), $urandom, 40'd200000));
    request_q.push_back(build_req(OP_REPORT, 16'h8000, 32'h0, 40'd200000));
    request_q.push_back(build_req(OP_WITHDRAW, 16'hFFFF, 32'h0, 40'd200000));
    // last seen ahead of now wraps to a huge age
    request_q.push_back(build_req(OP_SWEEP, 16'h0000, 32'h0, 40'd100));

    now_cursor = 40'd300000;
    for (ph = 0; ph < 6; ph++) begin
      drain();
      send_idle_pct = (ph < 2) ? 22 : (ph < 4) ? 50 : 0;
      recv_idle_pct = (ph < 2) ? 50 : (ph < 4) ? 22 : 0;
      case (ph)
        0: step_span = 40000;
        1: begin
          write_timeout('0);
          step_span = 3;
        end
        2: begin
          write_timeout('1);
          step_span = 32'h4000_0000;
          now_cursor = 40'hFF_F000_0000;
        end
        3: begin
          tmo = $urandom_range(1, 5000);
          write_timeout(tmo);
          step_span = tmo / 2 + 1;
        end
        4: begin
          write_timeout(32'd1000);
          step_span = 500;
        end
        default: begin
          write_timeout(TIMEOUT_RESET_MS);
          step_span = 40000;
        end
      endcase
      for (k = 0; k < 6; k++) hash_pool[k] = 16'($urandom);
      for (k = 0; k < 4; k++) ip_pool[k] = $urandom;
      for (k = 0; k < PHASE_ITEMS; k++) request_q.push_back(roll_request());
    end

    drain();
    repeat (ENTRIES + 8) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/srat_pkg.sv
hw/rtl/srat_store.sv
hw/rtl/srat_match.sv
hw/rtl/srat_seq.sv
hw/rtl/stream_registry_aging_table_unit.sv
hw/rtl/srat_checker.sv
tb/tb_stream_registry_aging_table_unit.sv
